// File: design/wpm_pkg.sv
// shared types, constants and codes for the work packet pool manager
package wpm_pkg;

  localparam int POOL_SIZE   = 256;
  localparam int ID_W        = 8;
  localparam int LINK_W      = $clog2(POOL_SIZE + 1);
  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

  typedef enum logic [1:0] {
    ACT_RETURN = 2'd0,
    ACT_INPUT  = 2'd1,
    ACT_OUTPUT = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_FULL         = 2'd0,
    CLS_EMPTY        = 2'd1,
    CLS_ALMOST_FULL  = 2'd2,
    CLS_ALMOST_EMPTY = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONE      = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_UNALLOC   = 3'd3,
    ST_WORK      = 3'd4,
    ST_ALL_EMPTY = 3'd5,
    ST_OUT       = 3'd6
  } status_t;

  // request and response payloads
  typedef struct packed {
    logic [1:0]       action;
    logic [ID_W-1:0]  packet_id;
    logic [CLS_W-1:0] packet_class;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic [2:0]        status;
    logic [LINK_W-1:0] allocated_total;
  } rsp_t;

  // list update applied by the store
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             alloc;
    logic [CLS_W-1:0] push_cls;
    logic [CLS_W-1:0] pop_cls;
    logic [ID_W-1:0]  push_id;
  } upd_t;

  // current list state seen by the control logic
  typedef struct packed {
    logic [NUM_CLASSES-1:0][LINK_W-1:0] heads;
    logic [NUM_CLASSES-1:0][LINK_W-1:0] counts;
    logic [LINK_W-1:0]                  alloc;
  } view_t;

endpackage

// File: design/work_packet_pool_manager_core.sv
// Packet pool manager: four LIFO packet lists by fullness class, with priority pop and
// allocation of new packet IDs. Each request first registers the request and reads the link
// of the list head it will pop from the link RAM, then applies the list update and loads the
// response register, waiting while a stalled response is held. The link RAM read comes ahead
// of the head update, and a new request is taken only after the previous one has loaded its
// response. The link RAM has no reset and needs no clearing pass; the block takes requests
// from the first cycle after reset.
module work_packet_pool_manager_core
  import wpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  req_t              item;
  logic              busy;
  logic              pop_hit;
  logic [CLS_W-1:0]  pop_cls;
  logic              pop_hit_next;
  logic [CLS_W-1:0]  pop_cls_next;
  logic              accept;
  logic              fire;
  logic [LINK_W-1:0] rd_data;
  logic              mark_hit;
  upd_t              upd;
  view_t             view;
  rsp_t              rsp_next;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign fire      = busy && (!rsp_valid || !rsp_stall);

  // pick the list to pop by priority, from heads that stay put until the update
  always_comb begin
    pop_hit_next = 1'b0;
    pop_cls_next = CLS_FULL;
    case (action_t'(req.action))
      ACT_INPUT: begin
        if (view.heads[CLS_FULL] < NULL_LINK) begin
          pop_hit_next = 1'b1;
          pop_cls_next = CLS_FULL;
        end else if (view.heads[CLS_ALMOST_FULL] < NULL_LINK) begin
          pop_hit_next = 1'b1;
          pop_cls_next = CLS_ALMOST_FULL;
        end else if (view.heads[CLS_ALMOST_EMPTY] < NULL_LINK) begin
          pop_hit_next = 1'b1;
          pop_cls_next = CLS_ALMOST_EMPTY;
        end
      end
      ACT_OUTPUT: begin
        if (view.heads[CLS_EMPTY] < NULL_LINK) begin
          pop_hit_next = 1'b1;
          pop_cls_next = CLS_EMPTY;
        end else if (view.heads[CLS_ALMOST_EMPTY] < NULL_LINK) begin
          pop_hit_next = 1'b1;
          pop_cls_next = CLS_ALMOST_EMPTY;
        end
      end
      default: begin
        pop_hit_next = 1'b0;
        pop_cls_next = CLS_FULL;
      end
    endcase
  end

  // request register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
    if (accept) begin
      item    <= req;
      pop_hit <= pop_hit_next;
      pop_cls <= pop_cls_next;
    end
  end

  wpm_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (view.heads[pop_cls_next][ID_W-1:0]),
    .rd_data  (rd_data),
    .mark_id  (item.packet_id),
    .mark_hit (mark_hit),
    .upd      (upd),
    .view     (view)
  );

  // decide the update and the response for the registered request
  always_comb begin
    upd          = '0;
    upd.push_cls = item.packet_class;
    upd.pop_cls  = pop_cls;
    upd.push_id  = item.packet_id;
    rsp_next            = '0;
    rsp_next.status     = ST_OK;
    case (action_t'(item.action))
      ACT_RETURN: begin
        if ({1'b0, item.packet_id} >= view.alloc) begin
          rsp_next.status = ST_UNALLOC;
        end else if (mark_hit) begin
          rsp_next.status = ST_QUEUED;
        end else begin
          upd.push = fire;
        end
      end
      ACT_INPUT: begin
        if (pop_hit) begin
          upd.pop             = fire;
          rsp_next.granted_id = view.heads[pop_cls][ID_W-1:0];
        end else begin
          rsp_next.status = ST_NONE;
        end
      end
      ACT_OUTPUT: begin
        if (pop_hit) begin
          upd.pop             = fire;
          rsp_next.granted_id = view.heads[pop_cls][ID_W-1:0];
        end else if (view.alloc < NULL_LINK) begin
          upd.alloc           = fire;
          rsp_next.granted_id = view.alloc[ID_W-1:0];
        end else begin
          rsp_next.status = ST_NONE;
        end
      end
      ACT_QUERY: begin
        if (view.heads[CLS_FULL] < NULL_LINK || view.heads[CLS_ALMOST_FULL] < NULL_LINK ||
            view.heads[CLS_ALMOST_EMPTY] < NULL_LINK) begin
          rsp_next.status = ST_WORK;
        end else if (view.counts[CLS_EMPTY] == view.alloc) begin
          rsp_next.status = ST_ALL_EMPTY;
        end else begin
          rsp_next.status = ST_OUT;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
    rsp_next.allocated_total = view.alloc + LINK_W'(upd.alloc);
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: design/wpm_store.sv
// list state: link ram, list heads, list lengths, queued marks, allocation count
module wpm_store
  import wpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ID_W-1:0]   rd_addr,
  output logic [LINK_W-1:0] rd_data,
  input  logic [ID_W-1:0]   mark_id,
  output logic              mark_hit,
  input  upd_t              upd,
  output view_t             view
);

  logic [LINK_W-1:0]                  link_mem [POOL_SIZE];
  logic [NUM_CLASSES-1:0][LINK_W-1:0] heads;
  logic [NUM_CLASSES-1:0][LINK_W-1:0] counts;
  logic [POOL_SIZE-1:0]               marks;
  logic [LINK_W-1:0]                  alloc;

  // link ram: push writes the old head, pop reads the next link
  always_ff @(posedge clk) begin
    if (upd.push) begin
      link_mem[upd.push_id] <= heads[upd.push_cls];
    end
    if (rd_en) begin
      rd_data <= link_mem[rd_addr];
    end
  end

  // list heads, lengths, marks and allocation count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads[c]  <= NULL_LINK;
        counts[c] <= '0;
      end
      marks <= '0;
      alloc <= '0;
    end else begin
      if (upd.push) begin
        heads[upd.push_cls]  <= {1'b0, upd.push_id};
        counts[upd.push_cls] <= counts[upd.push_cls] + LINK_W'(1);
        marks[upd.push_id]   <= 1'b1;
      end
      if (upd.pop) begin
        heads[upd.pop_cls] <= rd_data;
        if (counts[upd.pop_cls] != '0) begin
          counts[upd.pop_cls] <= counts[upd.pop_cls] - LINK_W'(1);
        end
        marks[heads[upd.pop_cls][ID_W-1:0]] <= 1'b0;
      end
      if (upd.alloc) begin
        alloc <= alloc + LINK_W'(1);
      end
    end
  end

  assign mark_hit    = marks[mark_id];
  assign view.heads  = heads;
  assign view.counts = counts;
  assign view.alloc  = alloc;

endmodule

// File: design/wpm_checker.sv
// port checks for the packet pool manager and their bind to the top level
module wpm_checker
  import wpm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // one request in flight: the cycle after a request is taken, no other is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // a nonzero packet id is handed out only with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted_id != '0 |-> rsp.status == ST_OK)
    else $error("packet granted with a failing status");

  // allocation count never passes the pool size and never falls
  a_alloc_mono: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(rsp_valid) && !$past(rst) |->
      rsp.allocated_total >= $past(rsp.allocated_total) &&
      rsp.allocated_total <= LINK_W'(POOL_SIZE))
    else $error("allocation count out of order");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind work_packet_pool_manager_core wpm_checker u_wpm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: tb/sv/wpm_pool_checker.sv
// request/response checker with a cycle-free pool predictor for the packet pool manager
`timescale 1ns / 100ps

module wpm_pool_checker
  import wpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  req_t       req,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  rsp_t       rsp,
  output int         fail_count,
  output int         pending,
  output int         rsp_checked,
  output logic [6:0] status_seen
);

  // predicted pool state
  logic [LINK_W-1:0] next_link [POOL_SIZE];
  bit                on_list   [POOL_SIZE];
  logic [LINK_W-1:0] list_head [NUM_CLASSES];
  logic [LINK_W-1:0] list_len  [NUM_CLASSES];
  logic [LINK_W-1:0] alloc_ct;

  rsp_t predicted_rsps [$];

  function automatic void pool_clear();
    for (int i = 0; i < POOL_SIZE; i++) on_list[i] = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      list_head[c] = NULL_LINK;
      list_len[c]  = '0;
    end
    alloc_ct = '0;
  endfunction

  // pop the head of one class list, 0 when the list is empty
  function automatic bit take_head(input class_t c, output logic [ID_W-1:0] id);
    logic [LINK_W-1:0] h;
    h  = list_head[c];
    id = h[ID_W-1:0];
    if (h >= NULL_LINK) return 1'b0;
    list_head[c] = next_link[h[ID_W-1:0]];
    if (list_len[c] != '0) list_len[c] = list_len[c] - LINK_W'(1);
    on_list[h[ID_W-1:0]] = 1'b0;
    return 1'b1;
  endfunction

  // apply one request to the predicted pool and return its response
  function automatic rsp_t pool_apply(input req_t r);
    rsp_t              o;
    logic [ID_W-1:0]   id;
    class_t            cls;
    o.granted_id = '0;
    o.status     = ST_OK;
    cls          = class_t'(r.packet_class);
    case (action_t'(r.action))
      ACT_RETURN: begin
        if ({1'b0, r.packet_id} >= alloc_ct) begin
          o.status = ST_UNALLOC;
        end else if (on_list[r.packet_id]) begin
          o.status = ST_QUEUED;
        end else begin
          next_link[r.packet_id] = list_head[cls];
          list_head[cls]         = {1'b0, r.packet_id};
          list_len[cls]          = list_len[cls] + LINK_W'(1);
          on_list[r.packet_id]   = 1'b1;
        end
      end
      ACT_INPUT: begin
        if (take_head(CLS_FULL, id)) o.granted_id = id;
        else if (take_head(CLS_ALMOST_FULL, id)) o.granted_id = id;
        else if (take_head(CLS_ALMOST_EMPTY, id)) o.granted_id = id;
        else o.status = ST_NONE;
      end
      ACT_OUTPUT: begin
        if (take_head(CLS_EMPTY, id)) begin
          o.granted_id = id;
        end else if (take_head(CLS_ALMOST_EMPTY, id)) begin
          o.granted_id = id;
        end else if (alloc_ct < LINK_W'(POOL_SIZE)) begin
          o.granted_id = alloc_ct[ID_W-1:0];
          alloc_ct     = alloc_ct + LINK_W'(1);
        end else begin
          o.status = ST_NONE;
        end
      end
      default: begin
        if (list_head[CLS_FULL] < NULL_LINK || list_head[CLS_ALMOST_FULL] < NULL_LINK ||
            list_head[CLS_ALMOST_EMPTY] < NULL_LINK)
          o.status = ST_WORK;
        else if (list_len[CLS_EMPTY] == alloc_ct)
          o.status = ST_ALL_EMPTY;
        else
          o.status = ST_OUT;
      end
    endcase
    o.allocated_total = alloc_ct;
    return o;
  endfunction

  // compare responses first, then queue the prediction for a new request
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      pool_clear();
      predicted_rsps.delete();
      fail_count  <= 0;
      pending     <= 0;
      rsp_checked <= 0;
      status_seen <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_checked <= rsp_checked + 1;
        if (rsp.status < 3'd7) status_seen[rsp.status] <= 1'b1;
        if (predicted_rsps.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: response with no request waiting: id %0d status %0d total %0d",
                     $realtime, rsp.granted_id, rsp.status, rsp.allocated_total);
        end else begin
          exp_rsp = predicted_rsps.pop_front();
          if (rsp.granted_id !== exp_rsp.granted_id || rsp.status !== exp_rsp.status ||
              rsp.allocated_total !== exp_rsp.allocated_total) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"%0t: mismatch exp id %0d status %0d total %0d,",
                        " got id %0d status %0d total %0d"},
                       $realtime, exp_rsp.granted_id, exp_rsp.status, exp_rsp.allocated_total,
                       rsp.granted_id, rsp.status, rsp.allocated_total);
          end
        end
      end
      if (req_valid && !req_stall) predicted_rsps.push_back(pool_apply(req));
      pending <= predicted_rsps.size();
    end
  end

endmodule

// File: tb/sv/tb_work_packet_pool_manager_core.sv
// stimulus, handshake pacing and verdict for the packet pool manager core
`timescale 1ns / 100ps

module tb_work_packet_pool_manager_core;
  import wpm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int         fail_count;
  int         pending;
  int         rsp_checked;
  logic [6:0] status_seen;

  bit tx_idle;
  bit rx_idle;
  int stall_left;
  int stall_draw;
  int cycle_ct = 0;
  int issued_out;
  int act_count [4];

  work_packet_pool_manager_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  wpm_pool_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .pending     (pending),
    .rsp_checked (rsp_checked),
    .status_seen (status_seen)
  );

  always #2 clk = ~clk;

  // response side stall: a random hold after each accepted response, when rx_idle is set
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      stall_draw = rx_idle ? $urandom_range(0, 11) : 0;
      stall_left <= stall_draw;
      rsp_stall  <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= (stall_left > 1);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_ct <= cycle_ct + 1;
    if (cycle_ct == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one request, with an optional gap ahead of it
  task automatic send_request(input action_t a, input logic [ID_W-1:0] id,
                              input logic [CLS_W-1:0] cls);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid        <= 1'b1;
    req.action       <= a;
    req.packet_id    <= id;
    req.packet_class <= cls;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    act_count[a] = act_count[a] + 1;
    if (a == ACT_OUTPUT) issued_out = issued_out + 1;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // weighted random mix; returns mostly name IDs that can have been handed out
  task automatic mixed_requests(input int n, input int w_ret, input int w_in, input int w_out);
    int               pick;
    int               bound;
    logic [ID_W-1:0]  id;
    for (int i = 0; i < n; i++) begin
      pick  = $urandom_range(0, 99);
      bound = (issued_out > 255) ? 255 : issued_out;
      if ($urandom_range(0, 7) == 0) id = ID_W'($urandom_range(0, 255));
      else id = ID_W'($urandom_range(0, bound));
      if (pick < w_ret)
        send_request(ACT_RETURN, id, CLS_W'($urandom_range(0, 3)));
      else if (pick < w_ret + w_in)
        send_request(ACT_INPUT, ID_W'($urandom_range(0, 255)), CLS_W'($urandom_range(0, 3)));
      else if (pick < w_ret + w_in + w_out)
        send_request(ACT_OUTPUT, ID_W'($urandom_range(0, 255)), CLS_W'($urandom_range(0, 3)));
      else
        send_request(ACT_QUERY, ID_W'($urandom_range(0, 255)), CLS_W'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    issued_out = 0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    for (int i = 0; i < 4; i++) act_count[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, allocation, each class, duplicate and bad returns
    send_request(ACT_QUERY,  8'd0,   CLS_FULL);
    send_request(ACT_INPUT,  8'd0,   CLS_FULL);
    send_request(ACT_RETURN, 8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_RETURN, 8'd255, CLS_ALMOST_EMPTY);
    send_request(ACT_RETURN, 8'd0,   CLS_FULL);
    send_request(ACT_RETURN, 8'd0,   CLS_EMPTY);
    send_request(ACT_RETURN, 8'd1,   CLS_ALMOST_FULL);
    send_request(ACT_RETURN, 8'd2,   CLS_ALMOST_EMPTY);
    send_request(ACT_QUERY,  8'd0,   CLS_FULL);
    send_request(ACT_INPUT,  8'd0,   CLS_FULL);
    send_request(ACT_INPUT,  8'd0,   CLS_FULL);
    send_request(ACT_INPUT,  8'd0,   CLS_FULL);
    send_request(ACT_INPUT,  8'd0,   CLS_FULL);
    send_request(ACT_QUERY,  8'd0,   CLS_FULL);
    send_request(ACT_RETURN, 8'd0,   CLS_EMPTY);
    send_request(ACT_RETURN, 8'd1,   CLS_EMPTY);
    send_request(ACT_RETURN, 8'd2,   CLS_EMPTY);
    send_request(ACT_QUERY,  8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_RETURN, 8'd2,   CLS_ALMOST_EMPTY);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);
    send_request(ACT_OUTPUT, 8'd0,   CLS_FULL);

    // random mix with idling on both sides, then a full drain
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    mixed_requests(120, 35, 25, 30);
    req_valid <= 1'b0;
    wait_drained();

    // output heavy stretch with no idling, runs the pool out of IDs
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    mixed_requests(290, 0, 5, 85);

    // return heavy mix over the whole ID range, sender idles, receiver at random
    tx_idle = 1'b1;
    rx_idle = 1'($urandom_range(0, 1));
    mixed_requests(150, 45, 25, 20);
    req_valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("requests sent: %0d returns, %0d input, %0d output, %0d queries",
             act_count[ACT_RETURN], act_count[ACT_INPUT], act_count[ACT_OUTPUT],
             act_count[ACT_QUERY]);
    $display("responses checked: %0d, status codes seen (6..0): %b", rsp_checked, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
